/* src/smm_pkg.sv */
`default_nettype none
package smm_pkg;

   // Largest matrix dimension held in the element stores
   localparam int MaxDim = 64;
   localparam int IdxBits = $clog2(MaxDim);
   localparam int AddrBits = 2 * IdxBits;
   localparam int Depth = MaxDim * MaxDim;
   localparam int CntBits = $clog2(MaxDim + 1);

   // Fixed field widths
   localparam int ElemBits = 16;
   localparam int ProdBits = 2 * ElemBits;
   localparam int SumBits = 38;
   localparam int SizeBits = 7;
   localparam int PortIdxBits = 6;

   // Request modes
   localparam logic [1:0] ModeWriteA = 2'd0;
   localparam logic [1:0] ModeWriteB = 2'd1;
   localparam logic [1:0] ModeCompute = 2'd2;

   typedef enum logic [1:0] {
      StIdle,
      StIssue,
      StDrain,
      StHold
   } state_type;

   typedef struct packed {
      logic clear;
      logic data_vld;
   } mac_ctl_type;

   // Clamp the programmed size to the store dimension
   function automatic logic [CntBits-1:0] active_size(input logic [SizeBits-1:0] size);
      if (int'(size) > MaxDim) begin
         return CntBits'(MaxDim);
      end
      return CntBits'(size);
   endfunction

   // Map a port index onto a store index
   function automatic logic [IdxBits-1:0] to_idx(input logic [PortIdxBits-1:0] idx);
      return IdxBits'(idx);
   endfunction

endpackage
`default_nettype wire

/* src/smm_ram.sv */
`default_nettype none
module smm_ram #(
   parameter int Width = 16,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/smm_mac.sv */
`default_nettype none
module smm_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smm_pkg::mac_ctl_type                ctl,
   input  wire logic signed [smm_pkg::ElemBits-1:0] a_elem,
   input  wire logic signed [smm_pkg::ElemBits-1:0] b_elem,
   output logic signed      [smm_pkg::SumBits-1:0]  acc,
   output logic                                     busy
);

   logic signed [smm_pkg::ProdBits-1:0] prod_ff;
   logic                                prod_vld_ff;
   logic signed [smm_pkg::SumBits-1:0]  acc_ff;
   logic signed [smm_pkg::SumBits-1:0]  acc_in;

   // Register the product of one element pair
   always_ff @(posedge clock) begin
      prod_ff <= a_elem * b_elem;
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.data_vld;
      end
   end

   // Clear on a new dot product, otherwise add the registered product when it is valid
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + {{(smm_pkg::SumBits - smm_pkg::ProdBits){prod_ff[smm_pkg::ProdBits-1]}},
                            prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
   assign busy = prod_vld_ff;

endmodule
`default_nettype wire

/* src/square_matrix_multiply_core.sv */
// Square matrix multiply core. Mode 0 and mode 1 transactions write one Q8.8
// element of A or B into its 4096-entry store. A mode 2 transaction returns
// the exact Q22.16 dot product of A row and B column over the active size n
// (matrix_size clamped to 64): the core streams one element pair per cycle
// out of the two stores into a single multiply-accumulate, and returns zero
// without reading the stores when the row or column lies outside the active
// size. The core takes no new request while a compute is in flight; the
// result register lets a write follow while the last result still waits.
// Stores have no reset and need no clearing pass: every element must be
// written before it is used.
`default_nettype none
module square_matrix_multiply_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic        [1:0]                      req_mode,
   input  wire logic        [smm_pkg::PortIdxBits-1:0] req_row,
   input  wire logic        [smm_pkg::PortIdxBits-1:0] req_col,
   input  wire logic signed [smm_pkg::ElemBits-1:0]    req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic             [smm_pkg::PortIdxBits-1:0] rsp_out_row,
   output logic             [smm_pkg::PortIdxBits-1:0] rsp_out_col,
   output logic signed      [smm_pkg::SumBits-1:0]     rsp_product_value,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic        [smm_pkg::SizeBits-1:0]    csr_matrix_size
);

   smm_pkg::state_type                 state_ff, state_in;
   logic [smm_pkg::SizeBits-1:0]       size_ff;
   logic [smm_pkg::CntBits-1:0]        n_ff, n_in;
   logic [smm_pkg::CntBits-1:0]        k_ff, k_in;
   logic [smm_pkg::PortIdxBits-1:0]    row_ff, row_in;
   logic [smm_pkg::PortIdxBits-1:0]    col_ff, col_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [smm_pkg::PortIdxBits-1:0]    rsp_row_ff;
   logic [smm_pkg::PortIdxBits-1:0]    rsp_col_ff;
   logic signed [smm_pkg::SumBits-1:0] rsp_sum_ff;
   logic                               load;
   logic                               accept;
   logic                               wr_ok;
   logic                               wr_a, wr_b;
   logic [smm_pkg::AddrBits-1:0]       wr_addr;
   logic [smm_pkg::AddrBits-1:0]       rd_addr_a, rd_addr_b;
   logic [smm_pkg::IdxBits-1:0]        k_idx;
   logic [smm_pkg::CntBits-1:0]        req_n;
   logic [smm_pkg::ElemBits-1:0]       a_data, b_data;
   logic signed [smm_pkg::SumBits-1:0] acc;
   logic                               mac_busy;
   smm_pkg::mac_ctl_type               mac_ctl;

   // Configuration register; a compute latches its size at acceptance
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= smm_pkg::SizeBits'(64);
      end else if (csr_valid) begin
         size_ff <= csr_matrix_size;
      end
   end

   assign req_ready = (state_ff == smm_pkg::StIdle);
   assign accept = req_valid && req_ready;
   assign req_n = smm_pkg::active_size(size_ff);

   // Element writes go straight into the stores
   assign wr_ok = (int'(req_row) < smm_pkg::MaxDim) && (int'(req_col) < smm_pkg::MaxDim);
   assign wr_a = accept && (req_mode == smm_pkg::ModeWriteA) && wr_ok;
   assign wr_b = accept && (req_mode == smm_pkg::ModeWriteB) && wr_ok;
   assign wr_addr = {smm_pkg::to_idx(req_row), smm_pkg::to_idx(req_col)};

   // Walk row of A and column of B
   assign k_idx = k_ff[smm_pkg::IdxBits-1:0];
   assign rd_addr_a = {smm_pkg::to_idx(row_ff), k_idx};
   assign rd_addr_b = {k_idx, smm_pkg::to_idx(col_ff)};

   smm_ram #(.Width(smm_pkg::ElemBits), .Depth(smm_pkg::Depth)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   smm_ram #(.Width(smm_pkg::ElemBits), .Depth(smm_pkg::Depth)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   smm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a_elem (a_data),
      .b_elem (b_data),
      .acc    (acc),
      .busy   (mac_busy)
   );

   // Sequence one compute transaction
   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      k_in = k_ff;
      row_in = row_ff;
      col_in = col_ff;
      rd_vld_in = 1'b0;
      load = 1'b0;
      mac_ctl.clear = 1'b0;
      mac_ctl.data_vld = rd_vld_ff;
      case (state_ff)
         smm_pkg::StIdle: begin
            if (accept && (req_mode == smm_pkg::ModeCompute)) begin
               n_in = req_n;
               k_in = '0;
               row_in = req_row;
               col_in = req_col;
               mac_ctl.clear = 1'b1;
               if ((int'(req_row) >= int'(req_n)) || (int'(req_col) >= int'(req_n))) begin
                  state_in = smm_pkg::StHold;
               end else begin
                  state_in = smm_pkg::StIssue;
               end
            end
         end
         smm_pkg::StIssue: begin
            rd_vld_in = 1'b1;
            k_in = smm_pkg::CntBits'(k_ff + 1'b1);
            if (smm_pkg::CntBits'(k_ff + 1'b1) == n_ff) begin
               state_in = smm_pkg::StDrain;
            end
         end
         smm_pkg::StDrain: begin
            if (!rd_vld_ff && !mac_busy) begin
               state_in = smm_pkg::StHold;
            end
         end
         smm_pkg::StHold: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load = 1'b1;
               state_in = smm_pkg::StIdle;
            end
         end
         default: begin
            state_in = smm_pkg::StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smm_pkg::StIdle;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
      n_ff <= n_in;
      k_ff <= k_in;
      row_ff <= row_in;
      col_ff <= col_in;
   end

   // Result register: load when the slot frees, drop on acceptance
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_row_ff <= row_ff;
         rsp_col_ff <= col_ff;
         rsp_sum_ff <= acc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_product_value = rsp_sum_ff;

   // A result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before acceptance");

   // The element index stays inside the active size while reading
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smm_pkg::StIssue) |-> (k_ff < n_ff))
      else $error("element index past active size");

   // The accumulator is settled once a result is ready to load
   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smm_pkg::StHold) |-> (!rd_vld_ff && !mac_busy))
      else $error("result loaded while products in flight");

   // The read of the last element is still valid on entry to the drain state
   a_issue_to_drain: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == smm_pkg::StIssue) && (state_in == smm_pkg::StDrain)) |=> rd_vld_ff)
      else $error("last element read lost");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;

   localparam logic [1:0] ModeUnused = 2'd3;
   localparam int SettleCycles = smm_pkg::MaxDim + 16;
   localparam int HoldOffCycles = 400;
   localparam int StallLimit = 4000;
   localparam int ItemTarget = 1350;

   typedef enum {RowCfg, RowReq, RowFillA, RowFillB} plan_kind_type;

   typedef struct {
      plan_kind_type     kind;
      logic [1:0]        mode;
      logic [5:0]        row;
      logic [5:0]        col;
      logic [15:0]       value;
      bit                typed;
      longint            product;
   } plan_row_type;

   typedef struct packed {
      logic [smm_pkg::PortIdxBits-1:0]   row;
      logic [smm_pkg::PortIdxBits-1:0]   col;
      logic signed [smm_pkg::SumBits-1:0] product;
   } c_elem_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic [1:0]                             req_mode;
   logic [smm_pkg::PortIdxBits-1:0]        req_row;
   logic [smm_pkg::PortIdxBits-1:0]        req_col;
   logic signed [smm_pkg::ElemBits-1:0]    req_value;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic [smm_pkg::PortIdxBits-1:0]        rsp_out_row;
   logic [smm_pkg::PortIdxBits-1:0]        rsp_out_col;
   logic signed [smm_pkg::SumBits-1:0]     rsp_product_value;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [smm_pkg::SizeBits-1:0]           csr_matrix_size;

   // Mirror of the element stores and the size register
   logic signed [smm_pkg::ElemBits-1:0] a_elems [smm_pkg::Depth];
   logic signed [smm_pkg::ElemBits-1:0] b_elems [smm_pkg::Depth];
   bit                                  a_loaded [smm_pkg::Depth];
   bit                                  b_loaded [smm_pkg::Depth];
   logic [smm_pkg::SizeBits-1:0]        size_reg;

   c_elem_type   expected_c [$];
   c_elem_type   want_c;
   int           error_count = 0;
   int           item_count = 0;
   int           results_seen = 0;
   int           stall_cycles = 0;
   int           hold_cycles = 0;
   bit           hold_request = 1'b0;
   plan_row_type directed_plan [];

   square_matrix_multiply_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_matrix_size   (csr_matrix_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Rows and columns in use, with oversize settings clamped
   function automatic int live_dim();
      return (int'(size_reg) > smm_pkg::MaxDim) ? smm_pkg::MaxDim : int'(size_reg);
   endfunction

   // Exact dot product of A row r and B column c over the live size
   function automatic logic signed [smm_pkg::SumBits-1:0] c_element(input int r, input int c);
      logic signed [smm_pkg::SumBits-1:0]  acc;
      logic signed [smm_pkg::ElemBits-1:0] x;
      logic signed [smm_pkg::ElemBits-1:0] y;
      int                                  n;
      n = live_dim();
      acc = '0;
      if (r >= n || c >= n) begin
         return '0;
      end
      for (int k = 0; k < n; k++) begin
         x = a_elems[r * smm_pkg::MaxDim + k];
         y = b_elems[k * smm_pkg::MaxDim + c];
         acc = acc + x * y;
      end
      return acc;
   endfunction

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one request transaction and fold it into the mirror once accepted
   task automatic send_req(input logic [1:0] mode, input int row, input int col,
                           input logic [15:0] value, input bit typed, input longint product);
      c_elem_type want;
      int         idx;
      if (item_count < 400 || item_count >= 600) begin
         while ($urandom_range(0, 99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_row <= smm_pkg::PortIdxBits'(row);
      req_col <= smm_pkg::PortIdxBits'(col);
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      idx = row * smm_pkg::MaxDim + col;
      case (mode)
         smm_pkg::ModeWriteA: begin
            a_elems[idx] = value;
            a_loaded[idx] = 1'b1;
         end
         smm_pkg::ModeWriteB: begin
            b_elems[idx] = value;
            b_loaded[idx] = 1'b1;
         end
         smm_pkg::ModeCompute: begin
            want.row = smm_pkg::PortIdxBits'(row);
            want.col = smm_pkg::PortIdxBits'(col);
            want.product = typed ? smm_pkg::SumBits'(product) : c_element(row, col);
            expected_c.push_back(want);
         end
         default: ;
      endcase
      item_count++;
   endtask

   // Load any operand the product still lacks, then request the element
   task automatic issue_compute(input int r, input int c);
      int n;
      n = live_dim();
      if (r < n && c < n) begin
         for (int k = 0; k < n; k++) begin
            if (!a_loaded[r * smm_pkg::MaxDim + k]) begin
               send_req(smm_pkg::ModeWriteA, r, k, rand_elem(), 1'b0, 0);
            end
            if (!b_loaded[k * smm_pkg::MaxDim + c]) begin
               send_req(smm_pkg::ModeWriteB, k, c, rand_elem(), 1'b0, 0);
            end
         end
      end
      send_req(smm_pkg::ModeCompute, r, c, 16'($urandom), 1'b0, 0);
   endtask

   // Hold the request side quiet until every result is in and the core settles
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_c.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_size(input logic [smm_pkg::SizeBits-1:0] size);
      drain();
      csr_valid <= 1'b1;
      csr_matrix_size <= size;
      do @(posedge clock); while (!csr_ready);
      size_reg = size;
      csr_valid <= 1'b0;
   endtask

   // Pick an index in range; keep large sizes on a few rows and columns
   function automatic int pick_index(input int n);
      if (n > 16) begin
         case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 2;
            default: return n - 1;
         endcase
      end
      return $urandom_range(0, n - 1);
   endfunction

   // Stimulus: directed table, then random phases at changing sizes
   initial begin
      int n;
      int r;
      int c;
      int roll;
      int phase;
      int large_phases;
      logic [smm_pkg::SizeBits-1:0] size_pick;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= smm_pkg::ModeWriteA;
      req_row <= '0;
      req_col <= '0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_matrix_size <= '0;
      size_reg = 7'd64;
      phase = 0;
      large_phases = 0;

      directed_plan = '{
         '{RowCfg,   smm_pkg::ModeWriteA,  6'd0,  6'd0,  16'd1,    1'b0, 0},
         '{RowReq,   smm_pkg::ModeWriteA,  6'd0,  6'd0,  16'h7FFF, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeWriteB,  6'd0,  6'd0,  16'h7FFF, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd0,  6'd0,  16'h0000, 1'b1, 1073676289},
         '{RowReq,   smm_pkg::ModeWriteA,  6'd0,  6'd0,  16'h8000, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeWriteB,  6'd0,  6'd0,  16'h8000, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd0,  6'd0,  16'hFFFF, 1'b1, 1073741824},
         '{RowReq,   smm_pkg::ModeWriteB,  6'd0,  6'd0,  16'h7FFF, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd0,  6'd0,  16'h0000, 1'b1, -1073709056},
         '{RowReq,   smm_pkg::ModeCompute, 6'd63, 6'd63, 16'h0000, 1'b1, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd0,  6'd63, 16'h0000, 1'b1, 0},
         '{RowReq,   ModeUnused,           6'd63, 6'd63, 16'hFFFF, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeWriteA,  6'd63, 6'd63, 16'hFFFF, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeWriteB,  6'd63, 6'd63, 16'h0001, 1'b0, 0},
         '{RowCfg,   smm_pkg::ModeWriteA,  6'd0,  6'd0,  16'd0,    1'b0, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd0,  6'd0,  16'h0000, 1'b1, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd63, 6'd63, 16'h0000, 1'b1, 0},
         '{RowCfg,   smm_pkg::ModeWriteA,  6'd0,  6'd0,  16'd64,   1'b0, 0},
         '{RowFillA, smm_pkg::ModeWriteA,  6'd1,  6'd0,  16'h8000, 1'b0, 0},
         '{RowFillB, smm_pkg::ModeWriteB,  6'd0,  6'd1,  16'h8000, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd1,  6'd1,  16'h0000, 1'b1, 64'sd68719476736},
         '{RowFillB, smm_pkg::ModeWriteB,  6'd0,  6'd2,  16'h7FFF, 1'b0, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd1,  6'd2,  16'h0000, 1'b1, -64'sd68717379584},
         '{RowCfg,   smm_pkg::ModeWriteA,  6'd0,  6'd0,  16'd127,  1'b0, 0},
         '{RowReq,   smm_pkg::ModeCompute, 6'd1,  6'd1,  16'h0000, 1'b1, 64'sd68719476736},
         '{RowReq,   smm_pkg::ModeCompute, 6'd63, 6'd63, 16'h0000, 1'b0, 0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_plan[i]) begin
         case (directed_plan[i].kind)
            RowCfg: write_size(smm_pkg::SizeBits'(directed_plan[i].value));
            RowFillA: begin
               for (int k = 0; k < live_dim(); k++) begin
                  send_req(smm_pkg::ModeWriteA, directed_plan[i].row, k,
                           directed_plan[i].value, 1'b0, 0);
               end
            end
            RowFillB: begin
               for (int k = 0; k < live_dim(); k++) begin
                  send_req(smm_pkg::ModeWriteB, k, directed_plan[i].col,
                           directed_plan[i].value, 1'b0, 0);
               end
            end
            default: begin
               if (directed_plan[i].mode == smm_pkg::ModeCompute && !directed_plan[i].typed)
               begin
                  issue_compute(directed_plan[i].row, directed_plan[i].col);
               end else begin
                  send_req(directed_plan[i].mode, directed_plan[i].row, directed_plan[i].col,
                           directed_plan[i].value, directed_plan[i].typed,
                           directed_plan[i].product);
               end
            end
         endcase
      end

      // Random phases, each at a fresh size
      while (item_count < ItemTarget) begin
         phase++;
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            size_pick = '0;
         end else if (roll < 18 && large_phases < 3) begin
            size_pick = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
            large_phases++;
         end else if (roll < 26) begin
            size_pick = 7'($urandom_range(9, 16));
         end else begin
            size_pick = 7'($urandom_range(1, 8));
         end
         write_size(size_pick);
         n = live_dim();
         if (phase == 3) begin
            hold_request = 1'b1;
         end

         for (int j = 0; j < 48 && item_count < ItemTarget; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45 && n > 0) begin
               issue_compute(pick_index(n), pick_index(n));
            end else if (roll < 60 && n > 0) begin
               send_req(($urandom_range(0, 1) == 0) ? smm_pkg::ModeWriteA : smm_pkg::ModeWriteB,
                        $urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_elem(),
                        1'b0, 0);
            end else if (roll < 72) begin
               send_req(($urandom_range(0, 1) == 0) ? smm_pkg::ModeWriteA : smm_pkg::ModeWriteB,
                        $urandom_range(0, smm_pkg::MaxDim - 1),
                        $urandom_range(0, smm_pkg::MaxDim - 1), rand_elem(), 1'b0, 0);
            end else if (roll < 84) begin
               // Compute outside the active size, which reads no stored entry; at full size, an in-range compute
               if (n >= smm_pkg::MaxDim) begin
                  issue_compute(pick_index(n), pick_index(n));
               end else begin
                  r = $urandom_range(0, smm_pkg::MaxDim - 1);
                  c = $urandom_range(n, smm_pkg::MaxDim - 1);
                  if ($urandom_range(0, 1) == 0) begin
                     send_req(smm_pkg::ModeCompute, c, r, 16'($urandom), 1'b0, 0);
                  end else begin
                     send_req(smm_pkg::ModeCompute, r, c, 16'($urandom), 1'b0, 0);
                  end
               end
            end else if (roll < 92) begin
               send_req(ModeUnused, $urandom_range(0, smm_pkg::MaxDim - 1),
                        $urandom_range(0, smm_pkg::MaxDim - 1), 16'($urandom), 1'b0, 0);
            end else begin
               send_req(smm_pkg::ModeWriteA, $urandom_range(0, smm_pkg::MaxDim - 1),
                        $urandom_range(0, smm_pkg::MaxDim - 1), rand_elem(), 1'b0, 0);
            end
         end
      end

      // Wait out the last results
      drain();
      if (error_count == 0 && expected_c.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off, one stretch always ready
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles = HoldOffCycles;
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (results_seen >= 100 && results_seen < 220) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 28);
         end
      end
   end

   // Check each result transaction against the oldest expected element
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_c.size() == 0) begin
            report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                      rsp_out_row, rsp_out_col, rsp_product_value));
         end else begin
            want_c = expected_c.pop_front();
            if (rsp_out_row !== want_c.row) begin
               report_mismatch($sformatf("out_row %0d, want %0d", rsp_out_row, want_c.row));
            end
            if (rsp_out_col !== want_c.col) begin
               report_mismatch($sformatf("out_col %0d, want %0d", rsp_out_col, want_c.col));
            end
            if (rsp_product_value !== want_c.product) begin
               report_mismatch($sformatf("product_value at (%0d,%0d) is %0d, want %0d",
                                         want_c.row, want_c.col, rsp_product_value,
                                         want_c.product));
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("TIMEOUT: no transaction for %0d cycles", StallLimit);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
